[rtl/core/ssme_pkg.sv]
// Shared codes and types for the sorted set merge engine.
package ssme_pkg;

  localparam int VALUE_W = 32;

  // Request codes carried in the input word's tuser
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // Merge modes held in the op_mode register
  localparam logic [1:0] MODE_UNION = 2'd0;
  localparam logic [1:0] MODE_INTER = 2'd1;
  localparam logic [1:0] MODE_DIFF  = 2'd2;

  // One result word as handed from the sequencer to the port
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               empty;
    logic               ovf;
  } res_t;

endpackage

[rtl/core/sorted_set_merge_engine_core.sv]
// Top level: stream ports, two list stores and the merge sequencer around one comparator.
// Loads: in_tready stays high while idle, so load words can follow back to back.
// Start: in_tready drops until the run closes; each merge step reads the stores, then compares,
// for s steps (s <= count_a + count_b), plus end check and close; out_tready stalls lengthen the drop.
// Each found word is held until the next is found or the run closes; the last goes out at close.
// Sync active-low reset clears counts, overflow flag, op_mode, output; stores keep contents.
module sorted_set_merge_engine_core #(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] elem_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic        out_tlast,
  output logic [1:0]  out_tuser   // [0] is_empty, [1] overflowed
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  logic                         a_we, b_we;
  logic [AW-1:0]                a_waddr, b_waddr, a_raddr, b_raddr;
  logic [ssme_pkg::VALUE_W-1:0] a_rdata, b_rdata;
  ssme_pkg::res_t               res;

  ssme_list_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_mem_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_waddr),
    .wdata (in_tdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  ssme_list_mem #(.DEPTH(MAX_LEN), .AW(AW)) u_mem_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (in_tdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  ssme_merge_ctrl #(.MAX_LEN(MAX_LEN), .AW(AW), .CW(CW)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser),
    .a_we      (a_we),
    .b_we      (b_we),
    .a_waddr   (a_waddr),
    .b_waddr   (b_waddr),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res)
  );

  // Pack the result word
  assign out_tdata = res.value;
  assign out_tlast = res.last;
  assign out_tuser = {res.ovf, res.empty};

endmodule

[rtl/core/ssme_list_mem.sv]
// Element store for one list: one write port, one registered read port.
module ssme_list_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [ssme_pkg::VALUE_W-1:0]     wdata,
  input  logic [AW-1:0]                    raddr,
  output logic [ssme_pkg::VALUE_W-1:0]     rdata
);

  logic [ssme_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write on load, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ssme_merge_ctrl.sv]
// Load bookkeeping and two-pointer merge sequencer around one shared comparator.
module ssme_merge_ctrl #(
  parameter int MAX_LEN = 32,
  parameter int AW      = 5,
  parameter int CW      = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_req,
  output logic                         a_we,
  output logic                         b_we,
  output logic [AW-1:0]                a_waddr,
  output logic [AW-1:0]                b_waddr,
  output logic [AW-1:0]                a_raddr,
  output logic [AW-1:0]                b_raddr,
  input  logic [ssme_pkg::VALUE_W-1:0] a_rdata,
  input  logic [ssme_pkg::VALUE_W-1:0] b_rdata,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssme_pkg::res_t               out_item
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_FLUSH
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic [CW-1:0]                count_a_r, count_a_nxt;
  logic [CW-1:0]                count_b_r, count_b_nxt;
  logic                         ovf_r, ovf_nxt;
  logic                         ovf_run_r, ovf_run_nxt;
  logic [CW-1:0]                i_r, i_nxt;
  logic [CW-1:0]                j_r, j_nxt;
  logic                         pend_valid_r, pend_valid_nxt;
  logic [ssme_pkg::VALUE_W-1:0] pend_val_r, pend_val_nxt;
  logic                         out_valid_r, out_valid_nxt;
  ssme_pkg::res_t               out_item_r, out_item_nxt;

  logic                         in_acc;
  logic                         a_full, b_full;
  logic                         have_a, have_b;
  logic                         lt, gt;
  logic                         emit, inc_i, inc_j, done;
  logic [ssme_pkg::VALUE_W-1:0] emit_val;
  logic                         out_free;
  logic                         push;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign a_full   = (count_a_r >= CW'(MAX_LEN));
  assign b_full   = (count_b_r >= CW'(MAX_LEN));
  assign out_free = !out_valid_r || out_ready;

  // Load writes land at the current fill count
  assign a_we    = in_acc && (in_req == ssme_pkg::REQ_LOAD_A) && !a_full;
  assign b_we    = in_acc && (in_req == ssme_pkg::REQ_LOAD_B) && !b_full;
  assign a_waddr = count_a_r[AW-1:0];
  assign b_waddr = count_b_r[AW-1:0];
  assign a_raddr = i_r[AW-1:0];
  assign b_raddr = j_r[AW-1:0];

  // Shared signed comparator on the two heads
  assign lt = $signed(a_rdata) < $signed(b_rdata);
  assign gt = $signed(b_rdata) < $signed(a_rdata);

  assign have_a = (i_r < count_a_r);
  assign have_b = (j_r < count_b_r);

  // Decide one merge step from the heads and the mode
  always_comb begin
    emit     = 1'b0;
    inc_i    = 1'b0;
    inc_j    = 1'b0;
    done     = 1'b0;
    emit_val = a_rdata;
    if (mode_r != ssme_pkg::MODE_UNION && mode_r != ssme_pkg::MODE_INTER &&
        mode_r != ssme_pkg::MODE_DIFF) begin
      done = 1'b1;
    end else if (have_a && have_b) begin
      if (lt) begin
        emit  = (mode_r != ssme_pkg::MODE_INTER);
        inc_i = 1'b1;
      end else if (gt) begin
        emit     = (mode_r == ssme_pkg::MODE_UNION);
        emit_val = b_rdata;
        inc_j    = 1'b1;
      end else begin
        emit  = (mode_r != ssme_pkg::MODE_DIFF);
        inc_i = 1'b1;
        inc_j = 1'b1;
      end
    end else if (have_a && mode_r != ssme_pkg::MODE_INTER) begin
      emit  = 1'b1;
      inc_i = 1'b1;
    end else if (have_b && mode_r == ssme_pkg::MODE_UNION) begin
      emit     = 1'b1;
      emit_val = b_rdata;
      inc_j    = 1'b1;
    end else begin
      done = 1'b1;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    ovf_nxt        = ovf_r;
    ovf_run_nxt    = ovf_run_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    pend_valid_nxt = pend_valid_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_item_nxt   = out_item_r;
    push           = 1'b0;

    if (cfg_we) begin
      mode_nxt = cfg_wdata;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_req)
            ssme_pkg::REQ_LOAD_A: begin
              if (a_full) begin
                ovf_nxt = 1'b1;
              end else begin
                count_a_nxt = count_a_r + CW'(1);
              end
            end
            ssme_pkg::REQ_LOAD_B: begin
              if (b_full) begin
                ovf_nxt = 1'b1;
              end else begin
                count_b_nxt = count_b_r + CW'(1);
              end
            end
            ssme_pkg::REQ_START: begin
              ovf_run_nxt = ovf_r;
              ovf_nxt     = 1'b0;
              i_nxt       = '0;
              j_nxt       = '0;
              state_nxt   = ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      // Wait for the heads at i and j
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (done) begin
          state_nxt = ST_FLUSH;
        end else if (!(emit && pend_valid_r && !out_free)) begin
          if (inc_i) begin
            i_nxt = i_r + CW'(1);
          end
          if (inc_j) begin
            j_nxt = j_r + CW'(1);
          end
          if (emit) begin
            // Hand the held word on; the new one waits to learn if it is last
            if (pend_valid_r) begin
              push          = 1'b1;
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{value: pend_val_r, last: 1'b0, empty: 1'b0,
                                ovf: ovf_run_r};
            end
            pend_valid_nxt = 1'b1;
            pend_val_nxt   = emit_val;
          end
          state_nxt = ST_RD;
        end
      end
      // Close the run: last word, or the empty marker
      ST_FLUSH: begin
        if (out_free) begin
          push           = 1'b1;
          out_valid_nxt  = 1'b1;
          out_item_nxt   = '{value: pend_valid_r ? pend_val_r : '0, last: 1'b1,
                             empty: !pend_valid_r, ovf: ovf_run_r};
          pend_valid_nxt = 1'b0;
          count_a_nxt    = '0;
          count_b_nxt    = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= ssme_pkg::MODE_UNION;
      count_a_r    <= '0;
      count_b_r    <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      count_a_r    <= count_a_nxt;
      count_b_r    <= count_b_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    ovf_run_r  <= ovf_run_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    pend_val_r <= pend_val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks on the sequencer
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_valid_r)
    else $error("held word left over outside a merge");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("output word overwritten before taken");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_a_r <= CW'(MAX_LEN) && count_b_r <= CW'(MAX_LEN))
    else $error("fill count beyond capacity");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> i_r <= count_a_r && j_r <= count_b_r)
    else $error("merge pointer ran past its list");

  a_flush_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && out_free |=> count_a_r == '0 && count_b_r == '0 && out_valid_r)
    else $error("run did not close cleanly");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the sorted set merge engine: stream stimulus, predictor, checker.
module tb_top;

  localparam int         LIST_DEPTH    = 32;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         CYCLE_LIMIT   = 300000;
  // Codes the package leaves unnamed
  localparam logic [1:0] REQ_IGNORED   = 2'd3;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] value;
  } req_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = 2'd0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] elem_value
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] result_value
  logic        out_tlast;
  logic [1:0]  out_tuser;       // [0] is_empty, [1] overflowed

  // Stimulus waiting for the driver and result words waiting for the checker
  req_word_t      pending_words[$];
  ssme_pkg::res_t expected_words[$];

  // Predictor state
  int         a_list[LIST_DEPTH];
  int         b_list[LIST_DEPTH];
  int         a_count = 0;
  int         b_count = 0;
  bit         ovf_flag = 1'b0;
  logic [1:0] merge_mode = ssme_pkg::MODE_UNION;

  // Run statistics
  int error_count = 0;
  int items_queued = 0;
  int loads_seen = 0;
  int starts_seen = 0;
  int ignored_seen = 0;
  int ovf_starts = 0;
  int empty_starts = 0;
  int words_checked = 0;
  int cycle_count = 0;

  sorted_set_merge_engine_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic ssme_pkg::res_t make_word(input int v, input bit ov);
    ssme_pkg::res_t w;
    w.value = v;
    w.last  = 1'b0;
    w.empty = 1'b0;
    w.ovf   = ov;
    return w;
  endfunction

  // Update the list state for one accepted word; queue the result list of a start
  task automatic predict_word(input logic [1:0] req, input logic [31:0] val);
    ssme_pkg::res_t merged[$];
    ssme_pkg::res_t w;
    int   i;
    int   j;
    int   x;
    int   y;
    bit   prev_ovf;
    case (req)
      ssme_pkg::REQ_LOAD_A: begin
        loads_seen++;
        if (a_count < LIST_DEPTH) begin
          a_list[a_count] = val;
          a_count++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      ssme_pkg::REQ_LOAD_B: begin
        loads_seen++;
        if (b_count < LIST_DEPTH) begin
          b_list[b_count] = val;
          b_count++;
        end else begin
          ovf_flag = 1'b1;
        end
      end
      ssme_pkg::REQ_START: begin
        starts_seen++;
        prev_ovf = ovf_flag;
        if (prev_ovf) ovf_starts++;
        i = 0;
        j = 0;
        if (merge_mode != MODE_UNUSED) begin
          // Two-pointer walk over both heads
          while (i < a_count && j < b_count) begin
            x = a_list[i];
            y = b_list[j];
            if (x < y) begin
              if (merge_mode != ssme_pkg::MODE_INTER)
                merged.push_back(make_word(x, prev_ovf));
              i++;
            end else if (y < x) begin
              if (merge_mode == ssme_pkg::MODE_UNION)
                merged.push_back(make_word(y, prev_ovf));
              j++;
            end else begin
              if (merge_mode != ssme_pkg::MODE_DIFF)
                merged.push_back(make_word(x, prev_ovf));
              i++;
              j++;
            end
          end
          // Drain the tails
          if (merge_mode != ssme_pkg::MODE_INTER)
            for (; i < a_count; i++) merged.push_back(make_word(a_list[i], prev_ovf));
          if (merge_mode == ssme_pkg::MODE_UNION)
            for (; j < b_count; j++) merged.push_back(make_word(b_list[j], prev_ovf));
        end
        if (merged.size() == 0) begin
          empty_starts++;
          w = make_word(0, prev_ovf);
          w.empty = 1'b1;
          merged.push_back(w);
        end
        w = merged.pop_back();
        w.last = 1'b1;
        merged.push_back(w);
        foreach (merged[k]) expected_words.push_back(merged[k]);
        a_count  = 0;
        b_count  = 0;
        ovf_flag = 1'b0;
      end
      default: ignored_seen++;
    endcase
  endtask

  // Input driver: bursts of words with random gaps between them
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    req_word_t next_word;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= $urandom_range(1, 24);
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_word(in_tuser, in_tdata);
      // Hold the current word until it is taken
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          next_word = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_word.value;
          in_tuser  <= next_word.req;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result receiver: stall style changes with bits [8:7] of a free-running counter
  logic [15:0] rx_cycle = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle   <= '0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      case (rx_cycle[8:7])
        2'd0:    out_tready <= 1'b1;
        2'd1:    out_tready <= ($urandom_range(0, 3) != 0);
        2'd2:    out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= (rx_cycle % 5 == 0);
      endcase
    end
  end

  // Result checker: compare each taken word with the oldest expectation
  always @(posedge clk) begin
    ssme_pkg::res_t exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: value %h", out_tdata);
        error_count++;
      end else begin
        exp_word = expected_words.pop_front();
        words_checked++;
        // The value of an empty-result word carries no meaning
        if (!exp_word.empty && out_tdata !== exp_word.value) begin
          $error("result_value mismatch: expected %h, got %h", exp_word.value, out_tdata);
          error_count++;
        end
        if (out_tlast !== exp_word.last) begin
          $error("is_last mismatch: expected %0b, got %0b", exp_word.last, out_tlast);
          error_count++;
        end
        if (out_tuser[0] !== exp_word.empty) begin
          $error("is_empty mismatch: expected %0b, got %0b", exp_word.empty, out_tuser[0]);
          error_count++;
        end
        if (out_tuser[1] !== exp_word.ovf) begin
          $error("overflowed mismatch: expected %0b, got %0b", exp_word.ovf, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sorted_set_merge_engine_core] ERROR");
      $finish;
    end
  end

  task automatic add_word(input logic [1:0] req, input logic [31:0] value);
    req_word_t w;
    w.req   = req;
    w.value = value;
    pending_words.push_back(w);
    if (req != REQ_IGNORED) items_queued++;
  endtask

  function automatic int pick_value(input int style);
    int s;
    s = (style == 3) ? $urandom_range(0, 2) : style;
    case (s)
      0: return $urandom;
      1: return $urandom_range(0, 15) - 8;
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'h8000_0000;
          1: return 32'h8000_0001;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return 32'h7FFF_FFFE;
          default: return 32'h7FFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 6);
    if (r < 17) return $urandom_range(7, 16);
    return $urandom_range(28, 34);
  endfunction

  // Queue loads of two lists in random interleave, with now and then an unused code, then a start
  task automatic queue_set(input int na, input int nb, input bit in_order);
    int vals[$];
    int a_vals[$];
    int b_vals[$];
    int style;
    int v;
    int pos;
    int ia;
    int ib;
    style = $urandom_range(0, 3);
    for (int side = 0; side < 2; side++) begin
      vals.delete();
      for (int n = 0; n < ((side == 0) ? na : nb); n++) begin
        v = pick_value(style);
        if (in_order) begin
          pos = 0;
          while (pos < vals.size() && vals[pos] <= v) pos++;
          vals.insert(pos, v);
        end else begin
          vals.push_back(v);
        end
      end
      if (side == 0) a_vals = vals;
      else b_vals = vals;
    end
    ia = 0;
    ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
        add_word(ssme_pkg::REQ_LOAD_A, a_vals[ia]);
        ia++;
      end else begin
        add_word(ssme_pkg::REQ_LOAD_B, b_vals[ib]);
        ib++;
      end
      if ($urandom_range(0, 29) == 0) add_word(REQ_IGNORED, $urandom);
    end
    add_word(ssme_pkg::REQ_START, $urandom);
  endtask

  // Wait until every word is taken and every result has come, then let the block settle
  task automatic drain_and_settle();
    @(posedge clk);
    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Random sets; the first one overruns a list
  task automatic run_random(input int item_goal);
    int first_item;
    int na;
    int nb;
    first_item = items_queued;
    na = pick_size();
    nb = pick_size();
    if ($urandom_range(0, 1) == 1) na = $urandom_range(33, 34);
    else nb = $urandom_range(33, 34);
    queue_set(na, nb, 1'b1);
    while (items_queued - first_item < item_goal)
      queue_set(pick_size(), pick_size(), $urandom_range(0, 9) != 0);
    drain_and_settle();
  endtask

  task automatic write_mode(input logic [1:0] mode);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we     <= 1'b0;
    merge_mode  = mode;
    @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Union: empty lists, extremes with a shared head, single-list starts, an unused code
    write_mode(ssme_pkg::MODE_UNION);
    add_word(ssme_pkg::REQ_START, 32'h1234_5678);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h8000_0000);
    add_word(ssme_pkg::REQ_LOAD_B, 32'h8000_0000);
    add_word(ssme_pkg::REQ_LOAD_A, 32'hFFFF_FFFF);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h0000_0000);
    add_word(ssme_pkg::REQ_LOAD_B, 32'h0000_0007);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h7FFF_FFFF);
    add_word(ssme_pkg::REQ_LOAD_B, 32'h7FFF_FFFF);
    add_word(REQ_IGNORED, 32'hFFFF_FFFF);
    add_word(ssme_pkg::REQ_START, 32'hFFFF_FFFF);
    add_word(ssme_pkg::REQ_LOAD_A, 32'd5);
    add_word(ssme_pkg::REQ_START, 32'd0);
    add_word(ssme_pkg::REQ_LOAD_B, -32'sd3);
    add_word(ssme_pkg::REQ_START, 32'd0);
    run_random(110);

    // Intersection with matches at both ends
    write_mode(ssme_pkg::MODE_INTER);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h8000_0000);
    add_word(ssme_pkg::REQ_LOAD_A, 32'd1);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h7FFF_FFFF);
    add_word(ssme_pkg::REQ_LOAD_B, 32'd1);
    add_word(ssme_pkg::REQ_LOAD_B, 32'd2);
    add_word(ssme_pkg::REQ_LOAD_B, 32'h7FFF_FFFF);
    add_word(ssme_pkg::REQ_START, 32'd0);
    run_random(95);

    // Difference: an equal pair is skipped
    write_mode(ssme_pkg::MODE_DIFF);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h8000_0000);
    add_word(ssme_pkg::REQ_LOAD_A, 32'd0);
    add_word(ssme_pkg::REQ_LOAD_A, 32'h7FFF_FFFF);
    add_word(ssme_pkg::REQ_LOAD_B, 32'd0);
    add_word(ssme_pkg::REQ_START, 32'd0);
    run_random(95);

    // Unused mode: every start yields the empty result
    write_mode(MODE_UNUSED);
    add_word(ssme_pkg::REQ_LOAD_A, 32'd1);
    add_word(ssme_pkg::REQ_LOAD_B, 32'd1);
    add_word(ssme_pkg::REQ_START, 32'd0);
    run_random(45);

    write_mode(ssme_pkg::MODE_UNION);
    run_random(25);

    if (expected_words.size() != 0) begin
      $error("%0d result words never arrived", expected_words.size());
      error_count++;
    end
    $display("Sent %0d loads and %0d starts (%0d unused codes) through all four modes",
             loads_seen, starts_seen, ignored_seen);
    $display("Checked %0d result words; %0d starts saw the overflow flag, %0d were empty",
             words_checked, ovf_starts, empty_starts);
    if (error_count == 0) begin
      $display("[sorted_set_merge_engine_core] OK");
    end else begin
      $display("[sorted_set_merge_engine_core] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ssme_pkg.sv
rtl/core/ssme_list_mem.sv
rtl/core/ssme_merge_ctrl.sv
rtl/core/sorted_set_merge_engine_core.sv
tb/tb_top.sv
